[design/isv_pkg.sv]
// shared types, constants and key functions for the index sort core
// no dependencies; imported by every design file
package isv_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 32;
	localparam int IN_W       = 32;
	localparam int POS_W      = 6;
	localparam int APB_DW     = 32;
	localparam int PADDR_W    = 3;
	localparam int IDX_W      = $clog2(MAX_ITEMS);
	localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	localparam value_t SIGN_VAL = value_t'(1) << (VALUE_BITS - 1);
	localparam value_t MAX_POS  = SIGN_VAL - value_t'(1);

	// register indexes
	localparam logic REG_DESCENDING = 1'b0;
	localparam logic REG_MAGNITUDE  = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_KEY,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT
	} state_t;

	// rank result written into the order buffer
	typedef struct packed {
		logic we;
		idx_t addr;
		idx_t data;
	} rank_wr_t;

	// read request from the sequencer to the order buffer
	typedef struct packed {
		logic issue;
		idx_t addr;
		logic last;
		logic ovf;
	} emit_req_t;

	// unsigned key whose unsigned order is the selected compare order
	function automatic value_t sort_key(value_t v, logic mag);
		value_t k;
		if (!mag) begin
			k = v ^ SIGN_VAL;
		end else if (v == SIGN_VAL) begin
			k = MAX_POS;
		end else if (v[VALUE_BITS-1]) begin
			k = value_t'(~v + value_t'(1));
		end else begin
			k = v;
		end
		return k;
	endfunction

	// element j ranks ahead of element i
	function automatic logic goes_before(value_t kj, value_t ki, logic desc, logic j_lower);
		logic strict;
		strict = desc ? (kj > ki) : (kj < ki);
		return strict || ((kj == ki) && j_lower);
	endfunction

endpackage

[design/isv_in_if.sv]
// input channel: one list element per item
// depends on isv_pkg
interface isv_in_if
	import isv_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] value;
	logic                   final_item;

	modport source (output valid, output value, output final_item, input ready);
	modport sink   (input valid, input value, input final_item, output ready);
endinterface

[design/isv_out_if.sv]
// result channel: one sorted position per item
// depends on isv_pkg
interface isv_out_if
	import isv_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             run_end;
	logic             overflowed;

	modport source (output valid, output position, output run_end, output overflowed,
		input ready);
	modport sink   (input valid, input position, input run_end, input overflowed,
		output ready);
endinterface

[design/isv_order_buf.sv]
// order buffer: memory of positions by rank, read pipeline and output register
// depends on isv_pkg, isv_out_if
module isv_order_buf
	import isv_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  rank_wr_t      wr,
	input  emit_req_t     req,
	output logic          can_issue,
	isv_out_if.source     result_out
);

	idx_t pos_mem [MAX_ITEMS];

	idx_t pos_s1;
	logic last_s1;
	logic ovf_s1;
	logic vld_s1;

	idx_t pos_q;
	logic last_q;
	logic ovf_q;
	logic out_vld_q;

	logic move;

	assign move      = vld_s1 && (!out_vld_q || result_out.ready);
	assign can_issue = !vld_s1 || move;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			pos_mem[wr.addr] <= wr.data;
		end
		if (req.issue) begin
			pos_s1  <= pos_mem[req.addr];
			last_s1 <= req.last;
			ovf_s1  <= req.ovf;
		end
		if (move) begin
			pos_q  <= pos_s1;
			last_q <= last_s1;
			ovf_q  <= ovf_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (req.issue) begin
				vld_s1 <= 1'b1;
			end else if (move) begin
				vld_s1 <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (result_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign result_out.valid      = out_vld_q;
	assign result_out.position   = POS_W'(pos_q);
	assign result_out.run_end    = last_q;
	assign result_out.overflowed = ovf_q;

endmodule

[design/index_sort_by_value_core.sv]
// index sort core: collects a list of signed Q16.16 values, emits their positions in order
// depends on isv_pkg, isv_in_if, isv_out_if, isv_order_buf
//
// Loading takes one item per cycle; elements are written into a value memory with one read
// port. On the item marked final_item the input stops (ready low) and each element is ranked:
// its key is read, then all n stored values are read back in turn and the ones that sort ahead
// of it are counted (ties keep the lower position first). Ranking is paced by that single read
// port, and the rank is written into a position memory. Emission then reads that memory back,
// one position per cycle while results are taken. The input reopens once the last read of the
// run is issued; results still in the output stage drain alongside the next load. Elements
// beyond 64 are dropped and every result of that list shows overflowed. Config (descending,
// compare_magnitude) sits at byte addresses 0 and 4 and is to be written only while idle;
// the block itself does not enforce this. No memory clearing pass is needed after reset.
module index_sort_by_value_core
	import isv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	isv_in_if.sink             item_in,
	isv_out_if.source          result_out
);

	// config registers
	logic desc_q;
	logic mag_q;
	logic cfg_wr;

	// sequencer
	state_t state_q, state_d;
	cnt_t   cnt_q, cnt_d;          // elements stored for this list
	logic   dropped_q, dropped_d;  // an element fell beyond capacity
	idx_t   i_q, i_d;              // element being ranked
	idx_t   j_q, j_d;              // element being compared against
	idx_t   e_q, e_d;              // rank being emitted
	idx_t   last_idx;
	logic   in_acc;

	// value memory and its read stage
	value_t val_mem [MAX_ITEMS];
	logic   rd_en;
	idx_t   rd_addr;
	logic   rd_key;                // read fetches the key of element i
	logic   rd_last;               // read is the last compare for element i
	value_t rdata_s1;
	logic   vld_s1;
	logic   key_s1;
	logic   last_s1;
	idx_t   jj_s1;

	// compare stage
	value_t key_rd;
	value_t keyi_q;
	idx_t   hit_q;
	logic   hit;

	rank_wr_t  rank_wr;
	emit_req_t emit_req;
	logic      can_issue;

	// apb port, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_DESCENDING: prdata[0] = desc_q;
			REG_MAGNITUDE:  prdata[0] = mag_q;
			default:        prdata    = '0;
		endcase
	end

	assign in_acc        = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == ST_LOAD);
	assign last_idx      = IDX_W'(cnt_q - cnt_t'(1));

	// next state and memory read sequencing
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		dropped_d = dropped_q;
		i_d       = i_q;
		j_d       = j_q;
		e_d       = e_q;
		rd_en     = 1'b0;
		rd_addr   = j_q;
		rd_key    = 1'b0;
		rd_last   = 1'b0;
		emit_req  = '{issue: 1'b0, addr: e_q, last: 1'b0, ovf: dropped_q};
		case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					if (cnt_q < cnt_t'(MAX_ITEMS)) begin
						cnt_d = cnt_q + cnt_t'(1);
					end else begin
						dropped_d = 1'b1;
					end
					if (item_in.final_item) begin
						i_d     = '0;
						state_d = ST_KEY;
					end
				end
			end
			ST_KEY: begin
				// fetch the key of element i
				rd_en   = 1'b1;
				rd_addr = i_q;
				rd_key  = 1'b1;
				j_d     = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// stream every stored value past the key
				rd_en   = 1'b1;
				rd_addr = j_q;
				rd_last = (j_q == last_idx);
				j_d     = j_q + idx_t'(1);
				if (j_q == last_idx) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// last compare settles and the rank is written this cycle
				if (i_q == last_idx) begin
					e_d     = '0;
					state_d = ST_EMIT;
				end else begin
					i_d     = i_q + idx_t'(1);
					state_d = ST_KEY;
				end
			end
			ST_EMIT: begin
				if (can_issue) begin
					emit_req.issue = 1'b1;
					emit_req.last  = (e_q == last_idx);
					e_d            = e_q + idx_t'(1);
					if (e_q == last_idx) begin
						// list is handed over, ready for the next one
						cnt_d     = '0;
						dropped_d = 1'b0;
						state_d   = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			e_q       <= '0;
			desc_q    <= 1'b0;
			mag_q     <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			dropped_q <= dropped_d;
			i_q       <= i_d;
			j_q       <= j_d;
			e_q       <= e_d;
			vld_s1    <= rd_en;
			if (cfg_wr) begin
				case (paddr[2])
					REG_DESCENDING: desc_q <= pwdata[0];
					REG_MAGNITUDE:  mag_q  <= pwdata[0];
					default:        desc_q <= desc_q;
				endcase
			end
		end
	end

	// value memory: one write port for loading, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < cnt_t'(MAX_ITEMS))) begin
			val_mem[cnt_q[IDX_W-1:0]] <= value_t'(item_in.value);
		end
		if (rd_en) begin
			rdata_s1 <= val_mem[rd_addr];
			key_s1   <= rd_key;
			last_s1  <= rd_last;
			jj_s1    <= rd_addr;
		end
	end

	// compare against the held key and count the elements that sort ahead
	assign key_rd = sort_key(rdata_s1, mag_q);
	assign hit    = vld_s1 && !key_s1 && goes_before(key_rd, keyi_q, desc_q, jj_s1 < i_q);

	always_ff @(posedge clk) begin
		if (vld_s1 && key_s1) begin
			keyi_q <= key_rd;
			hit_q  <= '0;
		end else if (hit) begin
			hit_q <= hit_q + idx_t'(1);
		end
	end

	// after the last compare the count is the rank of element i
	assign rank_wr = '{
		we:   vld_s1 && !key_s1 && last_s1,
		addr: hit_q + idx_t'(hit),
		data: i_q
	};

	isv_order_buf u_order_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (rank_wr),
		.req        (emit_req),
		.can_issue  (can_issue),
		.result_out (result_out)
	);

endmodule

[design/isv_checker.sv]
// port level checks for the index sort core, bound to the top level
// depends on isv_pkg, index_sort_by_value_core
module isv_checker
	import isv_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_final,
	input logic             out_valid,
	input logic             out_ready,
	input logic [POS_W-1:0] out_position,
	input logic             out_run_end,
	input logic             out_overflowed
);

	logic out_acc;
	logic in_acc;
	cnt_t res_cnt_q;  // results of the current run so far

	assign out_acc = out_valid && out_ready;
	assign in_acc  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (out_acc) begin
			res_cnt_q <= out_run_end ? cnt_t'(0) : res_cnt_q + cnt_t'(1);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_position)
		&& $stable(out_run_end) && $stable(out_overflowed))
		else $error("result changed while stalled");

	// ranking starts right after the last element, so input closes
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_final |=> !in_ready)
		else $error("input still open after final item");

	// a run never holds more results than the capacity
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> res_cnt_q < cnt_t'(MAX_ITEMS))
		else $error("run longer than capacity");

	// a run ends within capacity
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (res_cnt_q == cnt_t'(MAX_ITEMS - 1)) |-> out_run_end)
		else $error("run end missing at capacity");

endmodule

bind index_sort_by_value_core isv_checker u_isv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item_in.valid),
	.in_ready       (item_in.ready),
	.in_final       (item_in.final_item),
	.out_valid      (result_out.valid),
	.out_ready      (result_out.ready),
	.out_position   (result_out.position),
	.out_run_end    (result_out.run_end),
	.out_overflowed (result_out.overflowed)
);
